[hdl/txg_pkg.sv]
`timescale 1ns / 1ps
// txg_pkg: shared types and constants for the text cell glyph renderer.
// No dependencies; used by txg_req_if.sv, txg_rsp_if.sv, text_cell_glyph_renderer.sv and the bench.
package txg_pkg;

	// glyph geometry
	localparam int GLYPH_WIDTH  = 8;
	localparam int GLYPH_HEIGHT = 16;
	localparam int GLYPH_COUNT  = 256;

	// font store
	localparam int STORE_DEPTH = 4096;
	localparam int ADDR_W      = 12;
	localparam int BIT_AW      = ADDR_W + 3;

	// payload widths
	localparam int CODE_W = 8;
	localparam int ATTR_W = 8;
	localparam int BYTE_W = 8;
	localparam int ROW_W  = 4;
	localparam int PIX_W  = 32;

	// derived
	localparam int MAX_ROWS   = 16;
	localparam int ROWS       = (GLYPH_HEIGHT < MAX_ROWS) ? GLYPH_HEIGHT : MAX_ROWS;
	localparam int NPIX       = (GLYPH_WIDTH < 8) ? GLYPH_WIDTH : 8;
	localparam int GLYPH_BITS = GLYPH_WIDTH * GLYPH_HEIGHT;
	// a row can straddle two store bytes only when the width is not byte aligned
	localparam bit ROW_SPANS  = (GLYPH_WIDTH % 8) != 0;
	localparam int WIN_W      = 2 * BYTE_W;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_RENDER = 1'b1
	} txg_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LO,
		ST_HI,
		ST_EMIT
	} txg_state_t;

	typedef logic [CODE_W-1:0] code_t;
	typedef code_t code_tbl_t [2**CODE_W];

	// code -> glyph index, wrapped at the glyph count (built at elaboration)
	function automatic code_tbl_t build_code_wrap();
		code_tbl_t t;
		for (int i = 0; i < 2**CODE_W; i++) begin
			t[i] = CODE_W'(i % GLYPH_COUNT);
		end
		return t;
	endfunction

	localparam code_tbl_t CODE_WRAP = build_code_wrap();

endpackage

[hdl/txg_req_if.sv]
`timescale 1ns / 1ps
// txg_req_if: request channel (font write or cell render) with valid/ready.
// Depends on txg_pkg.
interface txg_req_if;
	import txg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [0:0]            command;
	logic [ADDR_W-1:0]     font_address;
	logic [BYTE_W-1:0]     font_byte;
	logic [CODE_W-1:0]     char_code;
	logic [ATTR_W-1:0]     attribute;

	modport source (
		output valid, command, font_address, font_byte, char_code, attribute,
		input  ready
	);
	modport sink (
		input  valid, command, font_address, font_byte, char_code, attribute,
		output ready
	);
endinterface

[hdl/txg_rsp_if.sv]
`timescale 1ns / 1ps
// txg_rsp_if: result channel, one glyph row per transfer, valid/ready.
// Depends on txg_pkg.
interface txg_rsp_if;
	import txg_pkg::*;

	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  glyph_row;
	logic [PIX_W-1:0]  row_pixels;
	logic              last_row;

	modport source (
		output valid, glyph_row, row_pixels, last_row,
		input  ready
	);
	modport sink (
		input  valid, glyph_row, row_pixels, last_row,
		output ready
	);
endinterface

[hdl/text_cell_glyph_renderer.sv]
`timescale 1ns / 1ps
// text_cell_glyph_renderer: text-mode character generator, font store plus row sequencer.
// Depends on txg_pkg, txg_req_if, txg_rsp_if.
//
//  channel | dir | request content
//  --------+-----+-------------------------------------------------------------
//  req     | in  | command, font_address, font_byte, char_code, attribute
//  rsp     | out | glyph_row, row_pixels, last_row (one per glyph row)
//
// A font write is taken while idle. A render launches the first store read on
// accept, then emits one row per cycle while rsp is not stalled and no row straddles
// two store bytes (a straddling row, only for widths that are not a multiple of 8,
// takes a second read). The single store port and the bit-address adder set the pace.
// req.ready is high only while idle. A stalled rsp holds the row in a window
// register and the sequencer waits. Reset clears control only; the store has
// no reset and reads garbage until written.
module text_cell_glyph_renderer (
	input  logic clk,
	input  logic arst_n,
	txg_req_if.sink   req,
	txg_rsp_if.source rsp
);
	import txg_pkg::*;

	txg_state_t st_q, st_d;

	// font store, single port, registered read
	logic [BYTE_W-1:0] font_store [STORE_DEPTH];
	logic [BYTE_W-1:0] rd_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_addr;

	// sequencer state
	logic [BIT_AW-1:0] bit_addr_q, bit_addr_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [WIN_W-1:0]  win_q, win_d;
	logic [3:0]        fg_q;
	logic [2:0]        bg_q;
	logic              ld_attr;

	// output register
	logic              out_valid_q;
	logic [ROW_W-1:0]  glyph_row_q;
	logic [PIX_W-1:0]  row_pixels_q;
	logic              last_row_q;

	logic              accept, out_free, emit, try_emit, last_c, spans_c;
	logic [BIT_AW-1:0] base_c, next_addr_c;
	logic [WIN_W-1:0]  win_c, shifted_c;
	logic [PIX_W-1:0]  pix_c;
	logic [CODE_W-1:0] code_c;

	assign accept   = req.valid && req.ready;
	assign req.ready = (st_q == ST_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	// glyph base bit address; wraps with the byte store
	assign code_c      = CODE_WRAP[req.char_code];
	assign base_c      = BIT_AW'(code_c * GLYPH_BITS);
	assign next_addr_c = bit_addr_q + BIT_AW'(GLYPH_WIDTH);
	assign last_c      = (row_q == ROW_W'(ROWS - 1));
	assign spans_c     = ROW_SPANS && ((4'(bit_addr_q[2:0]) + 4'(NPIX)) > 4'(8));

	// pixel window: low byte then the following byte, LSB first
	always_comb begin
		case (st_q)
			ST_LO:   win_c = {{BYTE_W{1'b0}}, rd_q};
			ST_HI:   win_c = {rd_q, win_q[BYTE_W-1:0]};
			default: win_c = win_q;
		endcase
	end

	assign shifted_c = win_c >> bit_addr_q[2:0];

	// color expansion: even pixel in the high nibble of each byte
	always_comb begin
		pix_c = '0;
		for (int x = 0; x < NPIX; x++) begin
			pix_c[8*(x/2) + ((x % 2 == 1) ? 0 : 4) +: 4] =
				shifted_c[x] ? fg_q : {1'b0, bg_q};
		end
	end

	// sequencer
	always_comb begin
		st_d       = st_q;
		bit_addr_d = bit_addr_q;
		row_d      = row_q;
		win_d      = win_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr   = bit_addr_q[BIT_AW-1:3];
		ld_attr    = 1'b0;
		try_emit   = 1'b0;
		emit       = 1'b0;

		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.command == CMD_WRITE) begin
						mem_we   = 1'b1;
						mem_addr = req.font_address;
					end else begin
						mem_re     = 1'b1;
						mem_addr   = base_c[BIT_AW-1:3];
						bit_addr_d = base_c;
						row_d      = '0;
						ld_attr    = 1'b1;
						st_d       = ST_LO;
					end
				end
			end
			ST_LO: begin
				if (spans_c) begin
					win_d    = win_c;
					mem_re   = 1'b1;
					mem_addr = bit_addr_q[BIT_AW-1:3] + ADDR_W'(1);
					st_d     = ST_HI;
				end else begin
					try_emit = 1'b1;
				end
			end
			ST_HI:   try_emit = 1'b1;
			ST_EMIT: try_emit = 1'b1;
			default: st_d = ST_IDLE;
		endcase

		if (try_emit) begin
			if (out_free) begin
				emit = 1'b1;
				if (last_c) begin
					st_d = ST_IDLE;
				end else begin
					bit_addr_d = next_addr_c;
					row_d      = row_q + ROW_W'(1);
					mem_re     = 1'b1;
					mem_addr   = next_addr_c[BIT_AW-1:3];
					st_d       = ST_LO;
				end
			end else begin
				// rsp stalled: park the row bits
				win_d = win_c;
				st_d  = ST_EMIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		bit_addr_q <= bit_addr_d;
		row_q      <= row_d;
		win_q      <= win_d;
		if (ld_attr) begin
			fg_q <= req.attribute[3:0];
			bg_q <= req.attribute[6:4];
		end
		if (emit) begin
			glyph_row_q  <= row_q;
			row_pixels_q <= pix_c;
			last_row_q   <= last_c;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			font_store[mem_addr] <= req.font_byte;
		end
		if (mem_re) begin
			rd_q <= font_store[mem_addr];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.glyph_row  = glyph_row_q;
	assign rsp.row_pixels = row_pixels_q;
	assign rsp.last_row   = last_row_q;

endmodule

[bench/text_cell_glyph_renderer_tb.sv]
`timescale 1ns / 1ps
// text_cell_glyph_renderer_tb: self-checking bench for the text cell glyph renderer.
// Loads glyphs via font writes, renders cells and checks every emitted row against a
// local row predictor. Depends on txg_pkg, txg_req_if, txg_rsp_if and the DUT.

typedef struct packed {
	logic [txg_pkg::ROW_W-1:0] row;
	logic [txg_pkg::PIX_W-1:0] pixels;
	logic                      last;
} glyph_row_t;

// Mirror of the font store plus the queue of rows still owed by the DUT.
class glyph_row_scoreboard;
	logic [txg_pkg::BYTE_W-1:0] font_copy [txg_pkg::STORE_DEPTH];
	bit                         font_written [txg_pkg::STORE_DEPTH];
	glyph_row_t                 pending_rows [$];
	int unsigned                mismatches;
	int unsigned                rows_checked;

	function new();
		mismatches   = 0;
		rows_checked = 0;
		foreach (font_written[i]) font_written[i] = 1'b0;
	endfunction

	// bit address of pixel x of row r in the glyph stream
	function int unsigned pixel_bit(logic [txg_pkg::CODE_W-1:0] code, int unsigned r,
			int unsigned x);
		return (code % txg_pkg::GLYPH_COUNT) * txg_pkg::GLYPH_BITS
			+ r * txg_pkg::GLYPH_WIDTH + x;
	endfunction

	// true once every store byte the cell will read has been written
	function bit glyph_loaded(logic [txg_pkg::CODE_W-1:0] code);
		int unsigned b;
		for (int r = 0; r < txg_pkg::ROWS; r++) begin
			for (int x = 0; x < txg_pkg::NPIX; x++) begin
				b = pixel_bit(code, r, x);
				if (!font_written[(b >> 3) % txg_pkg::STORE_DEPTH]) return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function void predict_cell(logic [txg_pkg::CODE_W-1:0] code,
			logic [txg_pkg::ATTR_W-1:0] attr);
		logic [3:0]  fg;
		logic [3:0]  bg;
		logic [3:0]  color;
		logic [7:0]  fbyte;
		int unsigned b;
		glyph_row_t  exp_row;
		fg = attr[3:0];
		bg = {1'b0, attr[6:4]};   // bit 7 is ignored
		for (int r = 0; r < txg_pkg::ROWS; r++) begin
			exp_row.row    = r[txg_pkg::ROW_W-1:0];
			exp_row.pixels = '0;
			exp_row.last   = (r == txg_pkg::ROWS - 1);
			for (int x = 0; x < txg_pkg::NPIX; x++) begin
				b     = pixel_bit(code, r, x);
				fbyte = font_copy[(b >> 3) % txg_pkg::STORE_DEPTH];
				color = fbyte[b % 8] ? fg : bg;
				// even pixel in the high nibble
				exp_row.pixels[8 * (x / 2) + ((x % 2) ? 0 : 4) +: 4] = color;
			end
			pending_rows.push_back(exp_row);
		end
	endfunction

	function void note_request(logic cmd, logic [txg_pkg::ADDR_W-1:0] addr,
			logic [txg_pkg::BYTE_W-1:0] data, logic [txg_pkg::CODE_W-1:0] code,
			logic [txg_pkg::ATTR_W-1:0] attr);
		if (cmd == txg_pkg::CMD_WRITE) begin
			font_copy[addr]    = data;
			font_written[addr] = 1'b1;
		end else begin
			predict_cell(code, attr);
		end
	endfunction

	function void check_row(logic [txg_pkg::ROW_W-1:0] row, logic [txg_pkg::PIX_W-1:0] pixels,
			logic last);
		glyph_row_t exp_row;
		if (pending_rows.size() == 0) begin
			$display("%0t: unexpected row: glyph_row %0d row_pixels %h last_row %0d",
				$time, row, pixels, last);
			mismatches++;
			return;
		end
		exp_row = pending_rows.pop_front();
		rows_checked++;
		if (row !== exp_row.row) begin
			$display("%0t: glyph_row expected %0d actual %0d", $time, exp_row.row, row);
			mismatches++;
		end
		if (pixels !== exp_row.pixels) begin
			$display("%0t: row %0d row_pixels expected %h actual %h",
				$time, exp_row.row, exp_row.pixels, pixels);
			mismatches++;
		end
		if (last !== exp_row.last) begin
			$display("%0t: row %0d last_row expected %0d actual %0d",
				$time, exp_row.row, exp_row.last, last);
			mismatches++;
		end
	endfunction
endclass

module text_cell_glyph_renderer_tb;
	import txg_pkg::*;

	localparam int CYCLE_LIMIT      = 400000; // far above the slowest legal run
	localparam int DRAIN_CYCLES     = 40;     // > one full cell plus launch
	localparam int TOTAL_ITEMS      = 210;
	localparam int LONG_STALL       = 400;    // receiver hold-off, fills the block
	localparam int STALL_AFTER_ROWS = 48;

	logic clk;
	logic arst_n;

	txg_req_if req_ch ();
	txg_rsp_if rsp_ch ();

	glyph_row_scoreboard sb = new();

	int unsigned       cycle_count = 0;
	int unsigned       items_sent  = 0;
	bit                calm_sender = 1'b0;
	logic [CODE_W-1:0] loaded_codes [$];

	text_cell_glyph_renderer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d rows outstanding", cycle_count,
				sb.pending_rows.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Monitors: both channels sampled at the rising edge, stimulus moves at the
	// falling edge, so what we see here is exactly what the DUT took.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.command, req_ch.font_address, req_ch.font_byte,
					req_ch.char_code, req_ch.attribute);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_row(rsp_ch.glyph_row, rsp_ch.row_pixels, rsp_ch.last_row);
		end
	end

	// Request driver. Entered and left at a falling edge; valid is touched at
	// most once per step so back-to-back requests keep it high.
	task automatic send_req(input txg_cmd_t cmd, input logic [ADDR_W-1:0] addr,
			input logic [BYTE_W-1:0] data, input logic [CODE_W-1:0] code,
			input logic [ATTR_W-1:0] attr);
		int unsigned gap;
		// toggle between bursty and gappy stretches now and then
		if ($urandom_range(0, 15) == 0) calm_sender = !calm_sender;
		gap = calm_sender ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= cmd;
		req_ch.font_address <= addr;
		req_ch.font_byte    <= data;
		req_ch.char_code    <= code;
		req_ch.attribute    <= attr;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// unused fields of each request carry random junk
	task automatic write_byte(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
		send_req(CMD_WRITE, addr, data, CODE_W'($urandom), ATTR_W'($urandom));
	endtask

	task automatic render_cell(input logic [CODE_W-1:0] code, input logic [ATTR_W-1:0] attr);
		send_req(CMD_RENDER, ADDR_W'($urandom), BYTE_W'($urandom), code, attr);
	endtask

	function automatic logic [BYTE_W-1:0] font_pattern();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return BYTE_W'($urandom);
		endcase
	endfunction

	function automatic void track_loaded(input logic [CODE_W-1:0] code);
		foreach (loaded_codes[i])
			if (loaded_codes[i] == code) return;
		if (sb.glyph_loaded(code)) loaded_codes.push_back(code);
	endfunction

	// Write the store bytes backing one glyph; max_bytes < full length gives
	// a truncated (broken) definition.
	task automatic define_glyph(input logic [CODE_W-1:0] code, input int unsigned max_bytes);
		int unsigned first_byte;
		int unsigned last_byte;
		first_byte = ((code % GLYPH_COUNT) * GLYPH_BITS) / 8;
		last_byte  = ((code % GLYPH_COUNT) * GLYPH_BITS + GLYPH_BITS - 1) / 8;
		for (int unsigned a = first_byte; a <= last_byte && a - first_byte < max_bytes; a++)
			write_byte(ADDR_W'(a % STORE_DEPTH), font_pattern());
		track_loaded(code);
	endtask

	// Receiver: random hold-offs, plus one long stall once traffic is flowing
	// so the DUT backs up and drops req.ready while requests are still offered.
	initial begin : rsp_side
		int unsigned gap;
		bit          calm;
		bit          stall_done;
		calm         = 1'b0;
		stall_done   = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!stall_done && sb.rows_checked >= STALL_AFTER_ROWS) begin
				gap        = LONG_STALL;
				stall_done = 1'b1;
			end else begin
				if ($urandom_range(0, 15) == 0) calm = !calm;
				gap = calm ? 0 : $urandom_range(0, 10);
			end
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic [BYTE_W-1:0] directed_rows [16];
		int unsigned       pick;
		bit                first_pass;
		directed_rows = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h0F, 8'hF0,
			8'h3C, 8'hC3, 8'h18, 8'h81, 8'h7E, 8'hE7, 8'h24, 8'h99};
		first_pass          = 1'b1;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.command      = CMD_WRITE;
		req_ch.font_address = '0;
		req_ch.font_byte    = '0;
		req_ch.char_code    = '0;
		req_ch.attribute    = '0;
		// hold reset over rising edges, release at a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: glyph 0 with edge patterns (all clear, all set, alternating,
		// single end bits), then attribute extremes. 8'h80 checks that bit 7 is
		// dropped; 8'h70 gives the widest background with a zero foreground.
		for (int unsigned a = 0; a < (GLYPH_BITS + 7) / 8; a++)
			write_byte(ADDR_W'(a), directed_rows[a % 16]);
		track_loaded('0);
		render_cell('0, 8'h00);
		render_cell('0, 8'hFF);
		render_cell('0, 8'h0F);
		render_cell('0, 8'h70);
		render_cell('0, 8'h80);

		// Random: mostly load-then-render sequences, some stray writes and
		// truncated glyph loads. The all-ones code goes first so the top of the
		// store and the highest code are both hit.
		while (items_sent < TOTAL_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (first_pass || loaded_codes.size() == 0 || pick < 2) begin
				define_glyph(first_pass ? {CODE_W{1'b1}} : CODE_W'($urandom), STORE_DEPTH);
				first_pass = 1'b0;
			end else if (pick < 8) begin
				render_cell(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)],
					ATTR_W'($urandom));
			end else if (pick == 8) begin
				write_byte(ADDR_W'($urandom), font_pattern());
			end else begin
				define_glyph(CODE_W'($urandom), $urandom_range(1, 4));
			end
		end
		req_ch.valid <= 1'b0;

		// drain; trailing writes leave nothing queued, so allow the latency too
		while (sb.pending_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending_rows.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
